@@ hdl/twpt_pkg.sv @@
// shared constants, types and codes of the trie prefix table
`default_nettype none

package twpt_pkg;

    localparam int NODE_COUNT    = 1024;
    localparam int ALPHABET_SIZE = 26;
    localparam int SLOT_COUNT    = NODE_COUNT * ALPHABET_SIZE;

    localparam int NODE_W   = $clog2(NODE_COUNT);
    localparam int FREE_W   = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W   = $clog2(SLOT_COUNT);
    localparam int KIND_W   = 2;
    localparam int LETTER_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_PREFIX = 2'd2,
        KIND_SPARE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP
    } t_state;

    // one child slot, with the word mark of the node it points to
    typedef struct packed {
        logic              mark;
        logic [NODE_W-1:0] child;
    } t_entry;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_entry            wr_data;
    } t_mem_req;

    typedef struct packed {
        t_kind               kind;
        logic [LETTER_W-1:0] letter;
        logic                has_letter;
        logic                last;
    } t_in_item;

    typedef struct packed {
        t_kind kind;
        logic  answer;
        logic  pool_full;
    } t_out_item;

endpackage

`default_nettype wire

@@ hdl/twpt_in_if.sv @@
// input channel of the trie prefix table: one letter item per transfer
`default_nettype none

interface twpt_in_if;
    import twpt_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    logic                has_letter;
    logic                last;

    modport source (output valid, kind, letter, has_letter, last, input ready);
    modport sink   (input valid, kind, letter, has_letter, last, output ready);
endinterface

`default_nettype wire

@@ hdl/twpt_out_if.sv @@
// output channel of the trie prefix table: one result item per word
`default_nettype none

interface twpt_out_if;
    import twpt_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] op_kind;
    logic              answer;
    logic              pool_full;

    modport source (output valid, op_kind, answer, pool_full, input ready);
    modport sink   (input valid, op_kind, answer, pool_full, output ready);
endinterface

`default_nettype wire

@@ hdl/trie_word_prefix_table_unit.sv @@
// top level of the trie prefix table: word walk control and result register
//
// Words come in on i_in one letter per item, tagged insert, exact search or
// prefix query; an item without a letter stands for the empty word. The item
// marked last produces one result on o_out with the echoed kind, the answer
// and the pool-full flag; other items produce nothing.
// For each item, the accept cycle issues the child slot read and
// the next cycle uses the read data, allocates a node or sets the word mark
// and writes the slot back. The registered read of the slot memory sets this
// loop, so the next item is taken only after the step of the one before. A
// result appears on o_out in the cycle after the step of the last item.
// Results sit in an output register; while it is full and o_out stalls, the
// block still takes the next item and only holds in its step cycle when a
// last item finds the register occupied.
// After reset the slot memory is swept to zero, one slot per cycle, over all
// 26624 slots; i_in.ready stays low during that sweep.
`default_nettype none

module trie_word_prefix_table_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    twpt_in_if.sink     i_in,
    twpt_out_if.source  o_out
);
    import twpt_pkg::*;

    t_state            r_state, n_state;
    t_in_item          r_item;
    logic [NODE_W-1:0] r_cur, n_cur;
    logic              r_cur_mark, n_cur_mark;
    logic              r_at_root, n_at_root;
    logic [ADDR_W-1:0] r_slot, n_slot;
    logic [ADDR_W-1:0] r_addr;
    logic              r_path_missing, n_path_missing;
    logic              r_insert_failed, n_insert_failed;
    logic [FREE_W-1:0] r_next_free, n_next_free;
    logic              r_root_mark, n_root_mark;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    t_mem_req          mem_req;
    t_entry            rd_data;
    logic              store_busy;

    logic              accept;
    logic              out_free;
    logic              step_go;
    logic              walk;
    logic              letter_ok;
    logic              alloc;
    logic              ok;
    logic              mark_now;
    logic              mark_write;
    logic [ADDR_W-1:0] slot_addr;

    twpt_node_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data),
        .o_busy    (store_busy)
    );

    assign accept    = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign slot_addr = ADDR_W'(r_cur) * ADDR_W'(ALPHABET_SIZE) + ADDR_W'(i_in.letter);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (!store_busy) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                if (step_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready = 1'b0;
        step_go    = 1'b0;
        case (r_state)
            ST_IDLE: i_in.ready = 1'b1;
            ST_STEP: step_go    = !r_item.last || out_free;
            default: begin
                i_in.ready = 1'b0;
                step_go    = 1'b0;
            end
        endcase
    end

    // walk one step and finish the word on the last item
    always_comb begin
        n_cur           = r_cur;
        n_cur_mark      = r_cur_mark;
        n_at_root       = r_at_root;
        n_slot          = r_slot;
        n_path_missing  = r_path_missing;
        n_insert_failed = r_insert_failed;
        n_next_free     = r_next_free;
        n_root_mark     = r_root_mark;
        alloc           = 1'b0;
        mark_write      = 1'b0;
        ok              = 1'b0;
        mark_now        = 1'b0;
        n_out           = r_out;

        walk      = r_item.has_letter && !r_path_missing && !r_insert_failed;
        letter_ok = r_item.letter < LETTER_W'(ALPHABET_SIZE);

        if (walk) begin
            if (!letter_ok) begin
                n_path_missing = 1'b1;
            end else if (rd_data.child != '0) begin
                n_cur      = rd_data.child;
                n_cur_mark = rd_data.mark;
                n_at_root  = 1'b0;
                n_slot     = r_addr;
            end else if (r_item.kind == KIND_INSERT) begin
                if (r_next_free < FREE_W'(NODE_COUNT)) begin
                    alloc       = 1'b1;
                    n_cur       = r_next_free[NODE_W-1:0];
                    n_cur_mark  = 1'b0;
                    n_at_root   = 1'b0;
                    n_slot      = r_addr;
                    n_next_free = r_next_free + FREE_W'(1);
                end else begin
                    n_insert_failed = 1'b1;
                end
            end else begin
                n_path_missing = 1'b1;
            end
        end

        if (r_item.last) begin
            ok       = !n_path_missing && !n_insert_failed;
            mark_now = n_at_root ? r_root_mark : n_cur_mark;
            n_out.kind      = r_item.kind;
            n_out.pool_full = 1'b0;
            case (r_item.kind)
                KIND_INSERT: begin
                    n_out.answer    = ok;
                    n_out.pool_full = n_insert_failed;
                    if (ok) begin
                        if (n_at_root) begin
                            n_root_mark = 1'b1;
                        end else begin
                            mark_write = 1'b1;
                            n_cur_mark = 1'b1;
                        end
                    end
                end
                KIND_SEARCH: n_out.answer = ok && mark_now;
                default:     n_out.answer = ok;
            endcase
        end

        mem_req.rd_en        = accept && i_in.has_letter;
        mem_req.rd_addr      = slot_addr;
        mem_req.wr_en        = step_go && (alloc || mark_write);
        mem_req.wr_addr      = n_slot;
        mem_req.wr_data.mark = n_cur_mark;
        mem_req.wr_data.child = n_cur;
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
        if (step_go && r_item.last) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_cur           <= '0;
            r_cur_mark      <= 1'b0;
            r_at_root       <= 1'b1;
            r_path_missing  <= 1'b0;
            r_insert_failed <= 1'b0;
            r_next_free     <= FREE_W'(1);
            r_root_mark     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (step_go) begin
                r_next_free <= n_next_free;
                r_root_mark <= n_root_mark;
                if (r_item.last) begin
                    r_cur           <= '0;
                    r_cur_mark      <= 1'b0;
                    r_at_root       <= 1'b1;
                    r_path_missing  <= 1'b0;
                    r_insert_failed <= 1'b0;
                end else begin
                    r_cur           <= n_cur;
                    r_cur_mark      <= n_cur_mark;
                    r_at_root       <= n_at_root;
                    r_path_missing  <= n_path_missing;
                    r_insert_failed <= n_insert_failed;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.kind       <= t_kind'(i_in.kind);
            r_item.letter     <= i_in.letter;
            r_item.has_letter <= i_in.has_letter;
            r_item.last       <= i_in.last;
            r_addr            <= slot_addr;
        end
        if (step_go) begin
            r_slot <= n_slot;
            if (r_item.last) begin
                r_out <= n_out;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.op_kind   = r_out.kind;
    assign o_out.answer    = r_out.answer;
    assign o_out.pool_full = r_out.pool_full;

endmodule

`default_nettype wire

@@ hdl/twpt_node_store.sv @@
// child slot memory of the trie with its clearing sweep after reset
`default_nettype none

module twpt_node_store (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire twpt_pkg::t_mem_req  i_req,
    output twpt_pkg::t_entry         o_rd_data,
    output logic                     o_busy
);
    import twpt_pkg::*;

    t_entry            r_mem [SLOT_COUNT];
    t_entry            r_rd_data;
    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    // sweep every slot to zero, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(SLOT_COUNT - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// testbench of the trie prefix table: directed, random and pool-exhaustion word streams
module tb_top;
    import twpt_pkg::*;

    localparam int MAX_LEN     = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [MAX_LEN*LETTER_W-1:0] letters;
        logic [4:0]                  len;
    } t_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    twpt_in_if  in_ch();
    twpt_out_if out_ch();

    trie_word_prefix_table_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // trie image kept alongside the block
    logic [NODE_W-1:0] child_of [SLOT_COUNT];
    bit                marked   [NODE_COUNT];
    logic [NODE_W-1:0] walk_node;
    bit                walk_missing;
    bit                walk_failed;
    logic [FREE_W-1:0] free_node;

    t_out_item pending_answers[$];
    t_word     stored_words[$];
    int        mismatch_count = 0;
    int        items_sent     = 0;
    int        src_idle_pct   = 0;
    int        sink_stall_pct = 0;
    int        cycle_count    = 0;

    function automatic void trie_clear();
        for (int i = 0; i < SLOT_COUNT; i++) child_of[i] = '0;
        for (int i = 0; i < NODE_COUNT; i++) marked[i] = 1'b0;
        walk_node    = '0;
        walk_missing = 1'b0;
        walk_failed  = 1'b0;
        free_node    = FREE_W'(1);
    endfunction

    function automatic bit trie_walk(input t_in_item it, output t_out_item res);
        int unsigned       slot;
        logic [NODE_W-1:0] nxt;
        bit                ok;
        res = '0;
        if (it.has_letter && !walk_missing && !walk_failed) begin
            if (it.letter >= ALPHABET_SIZE) begin
                walk_missing = 1'b1;
            end else begin
                slot = walk_node * ALPHABET_SIZE + it.letter;
                nxt  = child_of[slot];
                if (nxt != '0) begin
                    walk_node = nxt;
                end else if (it.kind == KIND_INSERT) begin
                    if (free_node < NODE_COUNT) begin
                        child_of[slot] = free_node[NODE_W-1:0];
                        walk_node      = free_node[NODE_W-1:0];
                        free_node      = free_node + 1'b1;
                    end else begin
                        walk_failed = 1'b1;
                    end
                end else begin
                    walk_missing = 1'b1;
                end
            end
        end
        if (!it.last) return 1'b0;
        ok       = !walk_missing && !walk_failed;
        res.kind = it.kind;
        case (it.kind)
            KIND_INSERT: begin
                if (ok) marked[walk_node] = 1'b1;
                res.answer    = ok;
                res.pool_full = walk_failed;
            end
            KIND_SEARCH: res.answer = ok && marked[walk_node];
            default:     res.answer = ok;
        endcase
        walk_node    = '0;
        walk_missing = 1'b0;
        walk_failed  = 1'b0;
        return 1'b1;
    endfunction

    task automatic send_item(t_kind kind, logic [LETTER_W-1:0] letter, bit has, bit last);
        t_in_item  it;
        t_out_item res;
        it = '{kind: kind, letter: letter, has_letter: has, last: last};
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.kind       <= it.kind;
        in_ch.letter     <= it.letter;
        in_ch.has_letter <= it.has_letter;
        in_ch.last       <= it.last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (trie_walk(it, res)) pending_answers.push_back(res);
        if (has || last) items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(int src_pct, int sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    function automatic t_word rand_word(int min_len, int max_len, int near_pct, int bad_pct);
        t_word w;
        int    r;
        w     = '0;
        w.len = 5'($urandom_range(max_len, min_len));
        for (int i = 0; i < w.len; i++) begin
            r = $urandom_range(99);
            if (r < bad_pct)
                w.letters[i*LETTER_W +: LETTER_W] =
                    LETTER_W'($urandom_range(31, ALPHABET_SIZE));
            else if (r < bad_pct + near_pct)
                w.letters[i*LETTER_W +: LETTER_W] = LETTER_W'($urandom_range(3));
            else
                w.letters[i*LETTER_W +: LETTER_W] =
                    LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
        end
        return w;
    endfunction

    // mixed: every item but the last walks with a random kind
    task automatic send_word(t_kind kind, t_word w, bit mixed);
        t_kind k;
        if (w.len == 0) begin
            send_item(kind, LETTER_W'($urandom_range(31)), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < w.len; i++) begin
            if ($urandom_range(99) < 4)
                send_item(t_kind'($urandom_range(3)), LETTER_W'($urandom_range(31)), 1'b0, 1'b0);
            k = (mixed && i != w.len - 1) ? t_kind'($urandom_range(3)) : kind;
            send_item(k, w.letters[i*LETTER_W +: LETTER_W], 1'b1, i == w.len - 1);
        end
    endtask

    task automatic check_empty_and_edge_words();
        set_idling(0, 0);
        send_item(KIND_SEARCH, 5'd31, 1'b0, 1'b1);
        send_item(KIND_PREFIX, 5'd0, 1'b0, 1'b1);
        send_item(KIND_INSERT, 5'd0, 1'b0, 1'b1);
        send_item(KIND_SEARCH, 5'd0, 1'b0, 1'b1);
        // letterless item inside a word
        send_item(KIND_INSERT, 5'd0, 1'b1, 1'b0);
        send_item(KIND_INSERT, 5'd31, 1'b0, 1'b0);
        send_item(KIND_INSERT, 5'd25, 1'b1, 1'b1);
        wait_drained();
        send_item(KIND_SEARCH, 5'd0, 1'b1, 1'b0);
        send_item(KIND_SEARCH, 5'd25, 1'b1, 1'b1);
        send_item(KIND_SEARCH, 5'd0, 1'b1, 1'b1);
        send_item(KIND_PREFIX, 5'd0, 1'b1, 1'b1);
        // letters past z
        send_item(KIND_INSERT, 5'd1, 1'b1, 1'b0);
        send_item(KIND_INSERT, 5'd31, 1'b1, 1'b1);
        send_item(KIND_SEARCH, 5'd26, 1'b1, 1'b1);
        send_item(KIND_SPARE, 5'd0, 1'b1, 1'b1);
        // mixed kinds within one word
        send_item(KIND_PREFIX, 5'd0, 1'b1, 1'b0);
        send_item(KIND_INSERT, 5'd25, 1'b1, 1'b1);
        send_item(KIND_SEARCH, 5'd5, 1'b1, 1'b0);
        send_item(KIND_INSERT, 5'd6, 1'b1, 1'b1);
        send_item(KIND_INSERT, 5'd2, 1'b1, 1'b0);
        send_item(KIND_SEARCH, 5'd3, 1'b1, 1'b1);
    endtask

    task automatic check_random_words(int item_budget);
        int    start_count;
        int    pick;
        t_kind kind;
        t_word w;
        start_count = items_sent;
        while (items_sent - start_count < item_budget) begin
            pick = $urandom_range(99);
            kind = pick < 40 ? KIND_INSERT : pick < 65 ? KIND_SEARCH :
                   pick < 92 ? KIND_PREFIX : KIND_SPARE;
            if (stored_words.size() != 0 && $urandom_range(99) < 60) begin
                w    = stored_words[$urandom_range(stored_words.size() - 1)];
                pick = $urandom_range(99);
                if (pick < 20 && w.len != 0) begin
                    w.len = 5'($urandom_range(w.len, 1));
                end else if (pick < 35 && w.len < MAX_LEN) begin
                    w.letters[w.len*LETTER_W +: LETTER_W] =
                        LETTER_W'($urandom_range(ALPHABET_SIZE - 1));
                    w.len = w.len + 1'b1;
                end
            end else if ($urandom_range(99) < 5) begin
                w = '0;
            end else begin
                w = rand_word(1, 8, 50, 3);
            end
            send_word(kind, w, $urandom_range(99) < 10);
            if (kind == KIND_INSERT) stored_words.push_back(w);
        end
    endtask

    task automatic check_pool_exhaustion();
        t_word w;
        int    pick;
        set_idling(12, 12);
        while (free_node < NODE_COUNT) begin
            w = rand_word(12, MAX_LEN, 0, 0);
            send_word(KIND_INSERT, w, 1'b0);
            stored_words.push_back(w);
        end
        for (int i = 0; i < 20; i++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_word(KIND_INSERT, rand_word(2, 8, 30, 0), 1'b0);
            end else begin
                w = stored_words[$urandom_range(stored_words.size() - 1)];
                send_word(pick < 60 ? KIND_INSERT : pick < 85 ? KIND_SEARCH : KIND_PREFIX,
                          w, 1'b0);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result, expected none, got kind %0d answer %0d full %0d",
                         $time, out_ch.op_kind, out_ch.answer, out_ch.pool_full);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (out_ch.op_kind !== want.kind) begin
                    $display("%0t: op_kind expected %0d, got %0d", $time, want.kind,
                             out_ch.op_kind);
                    mismatch_count++;
                end
                if (out_ch.answer !== want.answer) begin
                    $display("%0t: answer expected %0d, got %0d", $time, want.answer,
                             out_ch.answer);
                    mismatch_count++;
                end
                if (out_ch.pool_full !== want.pool_full) begin
                    $display("%0t: pool_full expected %0d, got %0d", $time, want.pool_full,
                             out_ch.pool_full);
                    mismatch_count++;
                end
            end
        end
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.kind       = KIND_INSERT;
        in_ch.letter     = '0;
        in_ch.has_letter = 1'b0;
        in_ch.last       = 1'b0;
        out_ch.ready     = 1'b0;
        trie_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_empty_and_edge_words();
        set_idling(0, 0);
        check_random_words(50);
        set_idling(80, 0);
        check_random_words(50);
        set_idling(0, 80);
        check_random_words(50);
        set_idling(12, 12);
        check_random_words(50);
        check_pool_exhaustion();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
